>>> design/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH + 2;
    localparam int NUM_TURNS   = 3;

    localparam logic [1:0] SEEN_MAX    = 2'd3;
    localparam logic [1:0] OUTLINE_MAX = 2'd2;

    // turn slots inside one job
    localparam int TURN_STEP = 0;   // prevprev -> prev -> new vertex
    localparam int TURN_WRAP = 1;   // prev -> new vertex -> first
    localparam int TURN_HEAD = 2;   // new vertex -> first -> second

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t x_coord;
        coord_t y_coord;
        logic   starts_outline;
        logic   last_vertex;
    } vertex_word_t;

    typedef struct packed {
        logic is_convex_flag;
        logic several_outlines;
    } result_word_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        point_t                 pp;
        point_t                 p;
        point_t                 v;
        point_t                 first;
        point_t                 second;
        logic [NUM_TURNS-1:0]   turn_en;
        logic                   last;
        logic                   several;
    } job_t;

    typedef struct packed {
        logic push;
        logic full;
    } push_ctl_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } pop_ctl_t;

endpackage

`default_nettype wire

>>> design/pcc_front.sv
`default_nettype none

module pcc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  vertex_valid,
    input  wire pcc_pkg::vertex_word_t vertex,
    output logic                       vertex_stall,
    output pcc_pkg::push_ctl_t         push_ctl_unused_guard,
    input  wire logic                  queue_full,
    output pcc_pkg::job_t              queue_job
);
    import pcc_pkg::*;

    point_t     first_reg,    first_next;
    point_t     second_reg,   second_next;
    point_t     prev_reg,     prev_next;
    point_t     prevprev_reg, prevprev_next;
    logic [1:0] seen_reg,     seen_next;
    logic [1:0] outline_reg,  outline_next;

    logic   accept;
    logic   opens;
    point_t vin;

    assign vertex_stall = queue_full;
    assign accept       = vertex_valid && !queue_full;

    assign push_ctl_unused_guard.push = accept;
    assign push_ctl_unused_guard.full = queue_full;

    assign vin.x = vertex.x_coord;
    assign vin.y = vertex.y_coord;
    assign opens = vertex.starts_outline || (seen_reg == 2'd0);

    always_comb
    begin
        logic [1:0] oc;
        oc = outline_reg;
        if (opens && (outline_reg < OUTLINE_MAX))
        begin
            oc = outline_reg + 2'd1;
        end

        queue_job.pp      = prevprev_reg;
        queue_job.p       = prev_reg;
        queue_job.v       = vin;
        queue_job.first   = first_reg;
        queue_job.second  = second_reg;
        queue_job.last    = vertex.last_vertex;
        queue_job.several = (oc == OUTLINE_MAX);
        queue_job.turn_en[TURN_STEP] = (seen_reg >= 2'd2);
        queue_job.turn_en[TURN_WRAP] = vertex.last_vertex && (seen_reg >= 2'd2);
        queue_job.turn_en[TURN_HEAD] = vertex.last_vertex && (seen_reg >= 2'd2);

        first_next    = first_reg;
        second_next   = second_reg;
        prev_next     = prev_reg;
        prevprev_next = prevprev_reg;
        seen_next     = seen_reg;
        outline_next  = outline_reg;
        if (accept)
        begin
            if (vertex.last_vertex)
            begin
                first_next    = '0;
                second_next   = '0;
                prev_next     = '0;
                prevprev_next = '0;
                seen_next     = 2'd0;
                outline_next  = 2'd0;
            end
            else
            begin
                if (seen_reg == 2'd0)
                begin
                    first_next = vin;
                end
                if (seen_reg == 2'd1)
                begin
                    second_next = vin;
                end
                prevprev_next = prev_reg;
                prev_next     = vin;
                seen_next     = (seen_reg < SEEN_MAX) ? seen_reg + 2'd1 : seen_reg;
                outline_next  = oc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg    <= '0;
            second_reg   <= '0;
            prev_reg     <= '0;
            prevprev_reg <= '0;
            seen_reg     <= 2'd0;
            outline_reg  <= 2'd0;
        end
        else
        begin
            first_reg    <= first_next;
            second_reg   <= second_next;
            prev_reg     <= prev_next;
            prevprev_reg <= prevprev_next;
            seen_reg     <= seen_next;
            outline_reg  <= outline_next;
        end
    end

endmodule

`default_nettype wire

>>> design/pcc_queue.sv
`default_nettype none

module pcc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pcc_pkg::push_ctl_t push_ctl,
    input  wire pcc_pkg::job_t      push_job,
    output logic                    full,
    input  wire logic               pop,
    output pcc_pkg::pop_ctl_t       pop_ctl,
    output pcc_pkg::job_t           head_job
);
    import pcc_pkg::*;

    localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

    job_t                 mem [DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg,  count_next;
    logic                 do_push, do_pop, empty;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push_ctl.push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    assign pop_ctl.pop   = do_pop;
    assign pop_ctl.empty = empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> design/pcc_back.sv
`default_nettype none

module pcc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pcc_pkg::pop_ctl_t     pop_ctl,
    input  wire pcc_pkg::job_t         head_job,
    output logic                       pop,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output pcc_pkg::result_word_t      result
);
    import pcc_pkg::*;

    typedef struct packed {
        logic signed [DIFF_WIDTH-1:0] d1x;
        logic signed [DIFF_WIDTH-1:0] d1y;
        logic signed [DIFF_WIDTH-1:0] d2x;
        logic signed [DIFF_WIDTH-1:0] d2y;
    } edges_t;

    typedef struct packed {
        logic signed [PROD_WIDTH-1:0] lhs;
        logic signed [PROD_WIDTH-1:0] rhs;
    } prods_t;

    typedef struct packed {
        edges_t [NUM_TURNS-1:0] e;
        logic   [NUM_TURNS-1:0] en;
        logic                   last;
        logic                   several;
    } s1_t;

    typedef struct packed {
        prods_t [NUM_TURNS-1:0] pr;
        logic   [NUM_TURNS-1:0] en;
        logic                   last;
        logic                   several;
    } s2_t;

    logic         s1_valid_reg, s1_valid_next;
    s1_t          s1_reg, s1_next;
    logic         s2_valid_reg, s2_valid_next;
    s2_t          s2_reg, s2_next;
    logic         sticky_reg, sticky_next;
    logic         out_valid_reg, out_valid_next;
    result_word_t out_reg, out_next;

    logic                 out_ready, s2_take, s2_ready, s1_take, s1_ready;
    logic [NUM_TURNS-1:0] neg;
    point_t               ta [NUM_TURNS];
    point_t               tb [NUM_TURNS];
    point_t               tc [NUM_TURNS];

    function automatic logic signed [DIFF_WIDTH-1:0] sub(input coord_t hi, input coord_t lo);
        sub = DIFF_WIDTH'(signed'({hi[COORD_WIDTH-1], hi}) - signed'({lo[COORD_WIDTH-1], lo}));
    endfunction

    assign out_ready = !out_valid_reg || !result_stall;
    assign s2_take   = s2_valid_reg && (!s2_reg.last || out_ready);
    assign s2_ready  = !s2_valid_reg || s2_take;
    assign s1_take   = s1_valid_reg && s2_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop       = s1_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        ta[TURN_STEP] = head_job.pp;
        tb[TURN_STEP] = head_job.p;
        tc[TURN_STEP] = head_job.v;
        ta[TURN_WRAP] = head_job.p;
        tb[TURN_WRAP] = head_job.v;
        tc[TURN_WRAP] = head_job.first;
        ta[TURN_HEAD] = head_job.v;
        tb[TURN_HEAD] = head_job.first;
        tc[TURN_HEAD] = head_job.second;
    end

    // stage 1: edge vectors
    always_comb
    begin
        for (int i = 0; i < NUM_TURNS; i++)
        begin
            s1_next.e[i].d1x = sub(tb[i].x, ta[i].x);
            s1_next.e[i].d1y = sub(tb[i].y, ta[i].y);
            s1_next.e[i].d2x = sub(tc[i].x, tb[i].x);
            s1_next.e[i].d2y = sub(tc[i].y, tb[i].y);
        end
        s1_next.en      = head_job.turn_en;
        s1_next.last    = head_job.last;
        s1_next.several = head_job.several;
        s1_valid_next   = s1_ready ? pop_ctl.pop : s1_valid_reg;
    end

    // stage 2: cross product terms
    always_comb
    begin
        for (int i = 0; i < NUM_TURNS; i++)
        begin
            s2_next.pr[i].lhs = s1_reg.e[i].d1x * s1_reg.e[i].d2y;
            s2_next.pr[i].rhs = s1_reg.e[i].d1y * s1_reg.e[i].d2x;
        end
        s2_next.en      = s1_reg.en;
        s2_next.last    = s1_reg.last;
        s2_next.several = s1_reg.several;
        s2_valid_next   = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    // stage 3: sign test, sticky flag, result
    always_comb
    begin
        for (int i = 0; i < NUM_TURNS; i++)
        begin
            neg[i] = s2_reg.en[i] && (s2_reg.pr[i].lhs < s2_reg.pr[i].rhs);
        end
        sticky_next    = sticky_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (s2_take)
        begin
            if (s2_reg.last)
            begin
                sticky_next               = 1'b0;
                out_valid_next            = 1'b1;
                out_next.is_convex_flag   = !(sticky_reg || (|neg)) && !s2_reg.several;
                out_next.several_outlines = s2_reg.several;
            end
            else
            begin
                sticky_next = sticky_reg || (|neg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> design/polygon_convexity_check.sv
// Polygon convexity check.
// Vertex channel: vertex_valid / vertex_stall carry one vertex word per
// accepted cycle (x, y, outline start mark, last-vertex mark). A vertex is
// taken at any edge with vertex_valid high and vertex_stall low.
// Result channel: result_valid / result_stall carry one word per polygon,
// produced after the vertex marked last.
// Throughput: one vertex per cycle while vertex_stall is low. The front end
// tracks the first two and last two vertices and queues one job per vertex;
// the back end forms up to three cross products per job in parallel (diff,
// multiply, compare stages); the last vertex's job passes the queue and
// each stage register before result_valid rises. vertex_stall rises only
// when the job queue (QUEUE_DEPTH entries) is full, which happens when
// result_stall holds a result and the pipe behind it fills up; a held
// result word stays stable until taken. Reset clears the vertex tracking,
// the queue and the pipeline; no result is pending after reset.
`default_nettype none

module polygon_convexity_check #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  vertex_valid,
    output logic                       vertex_stall,
    input  wire pcc_pkg::vertex_word_t vertex,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output pcc_pkg::result_word_t      result
);
    import pcc_pkg::*;

    push_ctl_t push_ctl;
    pop_ctl_t  pop_ctl;
    job_t      push_job;
    job_t      head_job;
    logic      queue_full;
    logic      pop;

    pcc_front u_front (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .vertex_valid          (vertex_valid),
        .vertex                (vertex),
        .vertex_stall          (vertex_stall),
        .push_ctl_unused_guard (push_ctl),
        .queue_full            (queue_full),
        .queue_job             (push_job)
    );

    pcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_ctl (push_ctl),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .pop_ctl  (pop_ctl),
        .head_job (head_job)
    );

    pcc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_ctl      (pop_ctl),
        .head_job     (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> design/pcc_checker.sv
`default_nettype none

module pcc_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  vertex_valid,
    input wire logic                  vertex_stall,
    input wire pcc_pkg::vertex_word_t vertex,
    input wire logic                  result_valid,
    input wire logic                  result_stall,
    input wire pcc_pkg::result_word_t result
);
    import pcc_pkg::*;

    a_vertex_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_stall |=> vertex_valid && $stable(vertex))
        else $error("vertex word changed while stalled");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.is_convex_flag && result.several_outlines))
        else $error("convex flag set with several outlines");

    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !vertex_stall && !result_valid)
        else $error("block not idle after reset");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !result_valid)
        else $error("result appeared without a vertex");

endmodule

bind polygon_convexity_check pcc_checker u_pcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

>>> tb/polygon_convexity_check_tb.sv
`timescale 1ns / 1ps

module polygon_convexity_check_tb;

    import pcc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int LONG_HOLD   = 300;
    localparam int COORD_MAX   = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int COORD_MIN   = -(1 << (COORD_WIDTH - 1));

    class convexity_predictor;
        point_t       first_pt;
        point_t       second_pt;
        point_t       prev_pt;
        point_t       prevprev_pt;
        logic [1:0]   seen_count;
        logic [1:0]   outline_count;
        bit           right_turn_seen;
        result_word_t pending_results[$];
        int           errors;

        function new();
            clear_polygon();
            errors = 0;
        endfunction

        function void clear_polygon();
            first_pt        = '0;
            second_pt       = '0;
            prev_pt         = '0;
            prevprev_pt     = '0;
            seen_count      = '0;
            outline_count   = '0;
            right_turn_seen = 1'b0;
        endfunction

        // exact sign of the z cross product of (b-a) and (c-b)
        function bit turns_right(point_t a, point_t b, point_t c);
            logic signed [PROD_WIDTH-1:0] ax, ay, bx, by, cx, cy, lhs, rhs;
            ax  = a.x;
            ay  = a.y;
            bx  = b.x;
            by  = b.y;
            cx  = c.x;
            cy  = c.y;
            lhs = (bx - ax) * (cy - by);
            rhs = (by - ay) * (cx - bx);
            return lhs < rhs;
        endfunction

        function void note_vertex(vertex_word_t w);
            point_t       v;
            result_word_t r;
            v.x = w.x_coord;
            v.y = w.y_coord;
            if ((w.starts_outline || seen_count == 0) && outline_count < OUTLINE_MAX)
                outline_count++;
            if (seen_count == 0)
                first_pt = v;
            else if (seen_count == 1)
                second_pt = v;
            else if (turns_right(prevprev_pt, prev_pt, v))
                right_turn_seen = 1'b1;
            prevprev_pt = prev_pt;
            prev_pt     = v;
            if (seen_count < SEEN_MAX)
                seen_count++;
            if (w.last_vertex)
            begin
                if (seen_count == SEEN_MAX)
                begin
                    if (turns_right(prevprev_pt, prev_pt, first_pt))
                        right_turn_seen = 1'b1;
                    if (turns_right(prev_pt, first_pt, second_pt))
                        right_turn_seen = 1'b1;
                end
                r.is_convex_flag   = !right_turn_seen && outline_count < OUTLINE_MAX;
                r.several_outlines = outline_count >= OUTLINE_MAX;
                pending_results.push_back(r);
                clear_polygon();
            end
        endfunction

        function void check_result(result_word_t got);
            result_word_t want;
            if (pending_results.size() == 0)
            begin
                $error("result word %b with none expected", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.is_convex_flag !== want.is_convex_flag)
            begin
                $error("is_convex_flag: expected %0b, got %0b",
                       want.is_convex_flag, got.is_convex_flag);
                errors++;
            end
            if (got.several_outlines !== want.several_outlines)
            begin
                $error("several_outlines: expected %0b, got %0b",
                       want.several_outlines, got.several_outlines);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         vertex_valid;
    logic         vertex_stall;
    vertex_word_t vertex;
    logic         result_valid;
    logic         result_stall;
    result_word_t result;

    convexity_predictor predictor = new();
    vertex_word_t       poly_q[$];
    int                 send_idle_pct;
    int                 recv_idle_pct;
    bit                 hold_req;

    polygon_convexity_check i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: random stall, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                predictor.check_result(result);
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic point_t make_point(int x, int y);
        point_t p;
        p.x = coord_t'(x);
        p.y = coord_t'(y);
        return p;
    endfunction

    function automatic int pick_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int any_coord();
        return pick_between(COORD_MIN, COORD_MAX);
    endfunction

    task automatic add_vertex(int x, int y, bit start);
        vertex_word_t w;
        w.x_coord        = coord_t'(x);
        w.y_coord        = coord_t'(y);
        w.starts_outline = start;
        w.last_vertex    = 1'b0;
        poly_q.push_back(w);
    endtask

    task automatic send_word(vertex_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            vertex_valid <= 1'b0;
            @(posedge clk);
        end
        vertex_valid <= 1'b1;
        vertex       <= w;
        do
            @(posedge clk);
        while (vertex_stall);
        predictor.note_vertex(w);
    endtask

    task automatic send_polygon();
        if (poly_q.size() == 0)
            return;
        poly_q[poly_q.size() - 1].last_vertex = 1'b1;
        foreach (poly_q[i])
            send_word(poly_q[i]);
        poly_q.delete();
    endtask

    // convex outlines come from corners and edge points of a box, in order
    task automatic make_random_polygon();
        point_t ring[$];
        int     kind, lo_x, hi_x, lo_y, hi_y, n;
        kind = $urandom_range(0, 99);
        lo_x = pick_between(COORD_MIN, COORD_MAX - 1);
        hi_x = pick_between(lo_x + 1, COORD_MAX);
        lo_y = pick_between(COORD_MIN, COORD_MAX - 1);
        hi_y = pick_between(lo_y + 1, COORD_MAX);
        if (kind < 70)
        begin
            if ($urandom_range(0, 3) != 0) ring.push_back(make_point(lo_x, lo_y));
            if ($urandom_range(0, 3) == 0)
                ring.push_back(make_point(pick_between(lo_x, hi_x), lo_y));
            if ($urandom_range(0, 3) != 0) ring.push_back(make_point(hi_x, lo_y));
            if ($urandom_range(0, 3) == 0)
                ring.push_back(make_point(hi_x, pick_between(lo_y, hi_y)));
            if ($urandom_range(0, 3) != 0) ring.push_back(make_point(hi_x, hi_y));
            if ($urandom_range(0, 3) == 0)
                ring.push_back(make_point(pick_between(lo_x, hi_x), hi_y));
            if ($urandom_range(0, 3) != 0) ring.push_back(make_point(lo_x, hi_y));
            if ($urandom_range(0, 3) == 0)
                ring.push_back(make_point(lo_x, pick_between(lo_y, hi_y)));
            if (ring.size() == 0)
                ring.push_back(make_point(lo_x, hi_y));
            repeat ($urandom_range(0, ring.size() - 1))
                ring.push_back(ring.pop_front());
            if (kind >= 45 && kind < 60)
                ring.reverse();
            else if (kind >= 60)
                ring[$urandom_range(0, ring.size() - 1)] =
                    make_point(lo_x + (hi_x - lo_x) / 2, lo_y + (hi_y - lo_y) / 2);
        end
        else
        begin
            if (kind >= 85)
                n = $urandom_range(1, 3);
            else if ($urandom_range(0, 19) == 0)
                n = $urandom_range(7, 24);
            else
                n = $urandom_range(1, 6);
            repeat (n)
                ring.push_back(make_point(any_coord(), any_coord()));
        end
        foreach (ring[i])
            add_vertex(ring[i].x, ring[i].y, 1'b0);
        poly_q[0].starts_outline = ($urandom_range(0, 4) != 0);
        if (poly_q.size() > 1 && $urandom_range(0, 7) == 0)
            poly_q[$urandom_range(1, poly_q.size() - 1)].starts_outline = 1'b1;
    endtask

    task automatic run_random(int n_vertices);
        int sent;
        sent = 0;
        while (sent < n_vertices)
        begin
            make_random_polygon();
            sent += poly_q.size();
            send_polygon();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        vertex_valid  = 1'b0;
        vertex        = '0;
        hold_req      = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 71;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone vertex, no start mark
        add_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_polygon();
        add_vertex(COORD_MIN, COORD_MAX, 1'b1);
        add_vertex(0, -1, 1'b0);
        send_polygon();
        // counter-clockwise and clockwise triangles at the corners of the range
        add_vertex(COORD_MIN, COORD_MIN, 1'b1);
        add_vertex(COORD_MAX, COORD_MIN, 1'b0);
        add_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_polygon();
        add_vertex(COORD_MIN, COORD_MIN, 1'b1);
        add_vertex(COORD_MAX, COORD_MAX, 1'b0);
        add_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_polygon();
        // collinear: zero cross product
        add_vertex(-1, -1, 1'b1);
        add_vertex(0, 0, 1'b0);
        add_vertex(1, 1, 1'b0);
        send_polygon();
        // second outline mid-polygon
        add_vertex(COORD_MIN, COORD_MIN, 1'b1);
        add_vertex(COORD_MAX, COORD_MIN, 1'b0);
        add_vertex(COORD_MAX, COORD_MAX, 1'b1);
        add_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_polygon();
        add_vertex(5592405, -5592406, 1'b0);
        add_vertex(-5592406, 5592405, 1'b1);
        send_polygon();
        // dent at the first vertex, seen only by the wrap turns
        add_vertex(3, 3, 1'b1);
        add_vertex(4, 0, 1'b0);
        add_vertex(4, 4, 1'b0);
        add_vertex(0, 4, 1'b0);
        send_polygon();

        run_random(200);

        send_idle_pct = 71;
        recv_idle_pct = 25;
        run_random(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (40)
        begin
            add_vertex(any_coord(), any_coord(), $urandom_range(0, 1));
            send_polygon();
        end
        run_random(160);

        vertex_valid <= 1'b0;
        while (predictor.pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (predictor.errors == 0 && predictor.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
